>>> hw/rtl/tilt_fusion_pid_macros.svh
// ---------------------------------------------------------------------------
// Tilt fusion PID assertion macros
// Concurrent assertion wrappers used by the top level of the tilt fusion block.
// ---------------------------------------------------------------------------
`ifndef TILT_FUSION_PID_MACROS_SVH
`define TILT_FUSION_PID_MACROS_SVH

`ifndef SYNTHESIS
`define TFP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tilt_fusion_pid assertion failed");
`define TFP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tilt_fusion_pid assertion failed");
`else
`define TFP_ASSERT_IMP(label, ante, cons)
`define TFP_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/tfp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tilt fusion PID package
// Shared widths, constants and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package tfp_pkg;

  localparam int ANGLE_FRAC_BITS  = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN        = 24;
  localparam int ATAN_W           = 30;

  localparam int MUL_AW     = 42;
  localparam int MUL_BW     = 34;
  localparam int MUL_PW     = 76;
  localparam int MUL_DIGITS = (MUL_BW + 3) / 4;
  localparam int MUL_LW     = MUL_DIGITS * 4;
  localparam int MUL_HW     = MUL_AW + 5;
  localparam int MUL_CW     = $clog2(MUL_DIGITS);

  localparam int DIV_NW = 64;
  localparam int DIV_DW = 32;
  localparam int DIV_CW = $clog2(DIV_NW);

  typedef logic [ATAN_W-1:0] atan_tab_t [TABLE_LEN];

  localparam logic [63:0] FIRST_ATANS [6] = '{
    64'd754974720, 64'd445687602, 64'd235489088,
    64'd119537938, 64'd60000934, 64'd30029717
  };

  function automatic atan_tab_t atan_table();
    atan_tab_t   tab;
    logic [63:0] big;
    logic [63:0] lin;
    logic [63:0] cub;
    big = 64'd961263669 << 20;
    for (int i = 0; i < TABLE_LEN; i++) begin
      if (i < 6) begin
        tab[i] = ATAN_W'(FIRST_ATANS[i]);
      end else begin
        lin = big >> i;
        cub = (3 * i < 64) ? (big >> (3 * i)) / 3 : 64'd0;
        tab[i] = ATAN_W'((lin - cub + 64'd524288) >> 20);
      end
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_Q24 = atan_table();

endpackage

>>> hw/rtl/tfp_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tilt fusion PID digit-serial multiplier
// Signed multiply by magnitudes, four multiplier bits per cycle.
// ---------------------------------------------------------------------------
module tfp_mul
  import tfp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [MUL_AW-1:0] a,
  input  logic signed [MUL_BW-1:0] b,
  output logic                     done,
  output logic signed [MUL_PW-1:0] prod,
  output logic        [MUL_PW-1:0] prod_mag
);

  logic                    running;
  logic [MUL_CW-1:0]       cnt;
  logic [MUL_AW-1:0]       a_mag;
  logic [MUL_HW-1:0]       hi;
  logic [MUL_LW-1:0]       lo;
  logic                    neg;
  logic [MUL_AW-1:0]       a_abs;
  logic [MUL_BW-1:0]       b_abs;
  logic [MUL_HW-1:0]       part;
  logic [MUL_HW-1:0]       acc;
  logic [MUL_HW+MUL_LW-1:0] full;

  assign a_abs = a[MUL_AW-1] ? MUL_AW'(-a) : MUL_AW'(a);
  assign b_abs = b[MUL_BW-1] ? MUL_BW'(-b) : MUL_BW'(b);
  assign part  = MUL_HW'(a_mag) * MUL_HW'(lo[3:0]);
  assign acc   = hi + part;
  assign full  = {hi, lo};
  assign prod_mag = full[MUL_PW-1:0];
  assign prod  = neg ? -$signed(prod_mag) : $signed(prod_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CW'(MUL_DIGITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_mag <= a_abs;
      hi    <= '0;
      lo    <= MUL_LW'(b_abs);
      neg   <= a[MUL_AW-1] ^ b[MUL_BW-1];
    end else if (running) begin
      hi <= acc >> 4;
      lo <= {acc[3:0], lo[MUL_LW-1:4]};
    end
  end

endmodule

>>> hw/rtl/tfp_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tilt fusion PID serial divider
// Unsigned restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module tfp_div
  import tfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quot
);

  logic              running;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW-1:0] dsor;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW:0]   trial;
  logic              take;

  assign trial = {rem, quot[DIV_NW-1]};
  assign take  = trial >= {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_NW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsor <= den;
      rem  <= '0;
      quot <= num;
    end else if (running) begin
      rem  <= take ? DIV_DW'(trial - {1'b0, dsor}) : DIV_DW'(trial);
      quot <= {quot[DIV_NW-2:0], take};
    end
  end

endmodule

>>> hw/rtl/tilt_fusion_pid.sv
`timescale 1ns / 1ps
// The 64-step divider (three uses) and the nine-digit multiplier (fourteen uses) do most of the work.
// A finished result waits in the output register while the next request is taken.
// Reset clears the fused angles, integrator, last error and last time stamp and loads
// the register defaults.
// ---------------------------------------------------------------------------
// Tilt fusion PID top level
// Accelerometer/gyro complementary filter for roll and pitch with a PID on roll.
// ---------------------------------------------------------------------------
`include "tilt_fusion_pid_macros.svh"

module tilt_fusion_pid
  import tfp_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic [31:0]        stamp_ms,
  input  logic signed [31:0] target_roll,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] drive,
  output logic signed [31:0] roll_est,
  output logic signed [31:0] pitch_est
);

  localparam int CW         = 34;
  localparam int STEP_W     = 5;
  localparam int ROOT_ITERS = 30;
  localparam int Y_SHIFT    = 14;
  localparam int ZR_SH      = 24 - ANGLE_FRAC_BITS;
  localparam logic signed [CW-1:0] Z_HALF = CW'(1 << (ZR_SH - 1));
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam logic [31:0] GYRO_DIV   = 32'd131000;
  localparam logic [31:0] GYRO_HALF  = 32'd65500;
  localparam logic [15:0] D_SCALE    = 16'd1000;

  localparam logic [2:0] REG_GAIN_P = 3'd0;
  localparam logic [2:0] REG_GAIN_I = 3'd1;
  localparam logic [2:0] REG_GAIN_D = 3'd2;
  localparam logic [2:0] REG_LIMIT  = 3'd3;
  localparam logic [2:0] REG_WEIGHT = 3'd4;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_SQB  = 15'b000000000000010,
    S_SQC  = 15'b000000000000100,
    S_ROOT = 15'b000000000001000,
    S_CORD = 15'b000000000010000,
    S_GYRO = 15'b000000000100000,
    S_INC  = 15'b000000001000000,
    S_BLG  = 15'b000000010000000,
    S_BLA  = 15'b000000100000000,
    S_MP   = 15'b000001000000000,
    S_MI   = 15'b000010000000000,
    S_MD   = 15'b000100000000000,
    S_MT   = 15'b001000000000000,
    S_DQ   = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  logic signed [23:0] gain_p, gain_i, gain_d;
  logic [14:0]        drive_limit;
  logic [15:0]        gyro_weight;

  logic signed [31:0] roll_angle, pitch_angle, last_error;
  logic signed [47:0] integral_sum;
  logic [31:0]        last_stamp;

  logic signed [15:0] ax, ay, az, gx, gy;
  logic signed [31:0] target;
  logic [31:0]        dt;
  logic               axis;
  logic [STEP_W-1:0]  step;
  logic               mul_go, div_go;

  logic [31:0]          sumsq;
  logic [59:0]          rad;
  logic [31:0]          rem_r;
  logic [29:0]          root;
  logic signed [CW-1:0] cx, cy, cz;
  logic signed [31:0]   acc_ang;
  logic [47:0]          gyro_mag;
  logic signed [31:0]   prop;
  logic signed [49:0]   m1;
  logic signed [31:0]   err;
  logic signed [39:0]   p_term;
  logic signed [40:0]   dq;
  logic signed [50:0]   t_val;
  logic signed [50:0]   d_term;

  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic                     mul_done;
  logic signed [MUL_PW-1:0] prod;
  logic [MUL_PW-1:0]        prod_mag;
  logic [DIV_NW-1:0]        div_num;
  logic [DIV_DW-1:0]        div_den;
  logic                     div_done;
  logic [DIV_NW-1:0]        div_quot;

  logic signed [16:0] a_sel;
  logic signed [15:0] b_sel, raw_sel;
  logic signed [31:0] ang_sel;
  logic [33:0]        rt_cur, rt_trial;
  logic               rt_take;
  logic [29:0]        root_nv;
  logic signed [CW-1:0] xs, ys, atan_e, cx_n, cy_n, cz_n, zr;
  logic               y_pos;
  logic signed [31:0] acc_nv;
  logic signed [49:0] inc_s, prop_sum, m2, bl_sum;
  logic signed [32:0] err_sum, err_diff;
  logic signed [31:0] err_nv;
  logic signed [39:0] ig;
  logic signed [48:0] int_sum;
  logic [50:0]        t_mag;
  logic signed [50:0] qd;
  logic signed [52:0] ds, lim53;
  logic signed [31:0] drive_nv;
  logic               out_load;
  logic               wr_en;
  logic [2:0]         reg_idx;
  logic               mul_state_next, div_state_next;

  tfp_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_go),
    .a        (mul_a),
    .b        (mul_b),
    .done     (mul_done),
    .prod     (prod),
    .prod_mag (prod_mag)
  );

  tfp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Configuration port.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    unique case (reg_idx)
      REG_GAIN_P: prdata = 32'(gain_p);
      REG_GAIN_I: prdata = 32'(gain_i);
      REG_GAIN_D: prdata = 32'(gain_d);
      REG_LIMIT:  prdata = {17'd0, drive_limit};
      REG_WEIGHT: prdata = {16'd0, gyro_weight};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p      <= 24'sd65536;
      gain_i      <= 24'sd65536;
      gain_d      <= 24'sd65536;
      drive_limit <= 15'd1000;
      gyro_weight <= 16'd64225;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GAIN_P: gain_p      <= pwdata[23:0];
        REG_GAIN_I: gain_i      <= pwdata[23:0];
        REG_GAIN_D: gain_d      <= pwdata[23:0];
        REG_LIMIT:  drive_limit <= pwdata[14:0];
        REG_WEIGHT: gyro_weight <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Axis selection: roll uses (ay, ax, az), pitch uses (-ax, ay, az).
  assign a_sel   = axis ? -17'(ax) : 17'(ay);
  assign b_sel   = axis ? ay : ax;
  assign raw_sel = axis ? gy : gx;
  assign ang_sel = axis ? pitch_angle : roll_angle;

  // Square root, two radicand bits per cycle.
  assign rt_cur   = {rem_r, rad[59:58]};
  assign rt_trial = {2'b00, root, 2'b01};
  assign rt_take  = rt_cur >= rt_trial;
  assign root_nv  = {root[28:0], rt_take};

  // CORDIC vectoring step.
  assign xs     = cx >>> step;
  assign ys     = cy >>> step;
  assign y_pos  = !cy[CW-1] && (cy != '0);
  assign atan_e = (step < STEP_W'(TABLE_LEN)) ? CW'({1'b0, ATAN_Q24[step]}) : '0;
  assign cx_n   = y_pos ? cx + ys : cx - ys;
  assign cy_n   = y_pos ? cy - xs : cy + xs;
  assign cz_n   = y_pos ? cz + atan_e : cz - atan_e;
  assign zr     = cz_n + Z_HALF;
  assign acc_nv = (a_sel == '0) ? '0 : 32'(zr >>> ZR_SH);

  // Gyro propagation and blend.
  assign inc_s    = 50'(div_quot[47:0]);
  assign prop_sum = 50'(ang_sel) + (raw_sel[15] ? -inc_s : inc_s);
  assign m2       = prod[49:0];
  assign bl_sum   = m1 + m2 + 50'sd32768;

  // PID arithmetic.
  assign err_sum  = 33'(roll_angle) - 33'(target);
  assign err_nv   = (err_sum[32] != err_sum[31]) ?
                    (err_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : err_sum[31:0];
  assign err_diff = 33'(err) - 33'(last_error);
  assign ig       = prod[55:16];
  assign int_sum  = 49'(integral_sum) + 49'(ig);
  assign t_mag    = t_val[50] ? 51'(-t_val) : 51'(t_val);
  assign qd       = div_quot[50:0];
  assign ds       = 53'(p_term) + 53'(integral_sum) + 53'(d_term);
  assign lim53    = 53'({drive_limit, {ANGLE_FRAC_BITS{1'b0}}});
  assign drive_nv = (ds > lim53) ? 32'(lim53) : ((ds < -lim53) ? 32'(-lim53) : ds[31:0]);

  always_comb begin
    unique case (state)
      S_SQB: begin
        mul_a = MUL_AW'(b_sel);
        mul_b = MUL_BW'(b_sel);
      end
      S_SQC: begin
        mul_a = MUL_AW'(az);
        mul_b = MUL_BW'(az);
      end
      S_GYRO: begin
        mul_a = MUL_AW'(raw_sel);
        mul_b = MUL_BW'({1'b0, dt});
      end
      S_BLG: begin
        mul_a = MUL_AW'(prop);
        mul_b = MUL_BW'({1'b0, gyro_weight});
      end
      S_BLA: begin
        mul_a = MUL_AW'(acc_ang);
        mul_b = MUL_BW'(WEIGHT_ONE - {1'b0, gyro_weight});
      end
      S_MP: begin
        mul_a = MUL_AW'(err);
        mul_b = MUL_BW'(gain_p);
      end
      S_MI: begin
        mul_a = MUL_AW'(err);
        mul_b = MUL_BW'(gain_i);
      end
      S_MD: begin
        mul_a = MUL_AW'(err_diff);
        mul_b = MUL_BW'(gain_d);
      end
      S_MT: begin
        mul_a = MUL_AW'(dq);
        mul_b = MUL_BW'(D_SCALE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    unique case (state)
      S_INC: begin
        div_num = (DIV_NW'(gyro_mag) << ANGLE_FRAC_BITS) + DIV_NW'(GYRO_HALF);
        div_den = DIV_DW'(GYRO_DIV);
      end
      S_DQ: begin
        div_num = DIV_NW'(t_mag);
        div_den = dt;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_SQB;
      S_SQB:  if (mul_done) state_next = S_SQC;
      S_SQC:  if (mul_done) state_next = S_ROOT;
      S_ROOT: if (step == STEP_W'(ROOT_ITERS - 1)) state_next = S_CORD;
      S_CORD: if (step == STEP_W'(CORDIC_STEPS - 1)) state_next = S_GYRO;
      S_GYRO: if (mul_done) state_next = S_INC;
      S_INC:  if (div_done) state_next = S_BLG;
      S_BLG:  if (mul_done) state_next = S_BLA;
      S_BLA:  if (mul_done) state_next = axis ? S_MP : S_SQB;
      S_MP:   if (mul_done) state_next = S_MI;
      S_MI:   if (mul_done) state_next = S_MD;
      S_MD:   if (mul_done) state_next = S_MT;
      S_MT:   if (mul_done) state_next = (dt == '0) ? S_OUT : S_DQ;
      S_DQ:   if (div_done) state_next = S_OUT;
      S_OUT:  if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    case (state_next) inside
      S_SQB, S_SQC, S_GYRO, S_BLG, S_BLA, S_MP, S_MI, S_MD, S_MT: mul_state_next = 1'b1;
      default: mul_state_next = 1'b0;
    endcase
    case (state_next) inside
      S_INC, S_DQ: div_state_next = 1'b1;
      default: div_state_next = 1'b0;
    endcase
  end

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mul_go       <= 1'b0;
      div_go       <= 1'b0;
      out_valid    <= 1'b0;
      step         <= '0;
      roll_angle   <= '0;
      pitch_angle  <= '0;
      integral_sum <= '0;
      last_error   <= '0;
      last_stamp   <= '0;
    end else begin
      state  <= state_next;
      mul_go <= (state_next != state) && mul_state_next;
      div_go <= (state_next != state) && div_state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_ROOT || state == S_CORD) begin
        step <= (state_next != state) ? '0 : step + 1'b1;
      end else begin
        step <= '0;
      end
      if (state == S_IDLE && in_valid) begin
        last_stamp <= stamp_ms;
      end
      if (state == S_BLA && mul_done) begin
        if (axis) begin
          pitch_angle <= bl_sum[47:16];
        end else begin
          roll_angle <= bl_sum[47:16];
        end
      end
      if (state == S_MI && mul_done) begin
        integral_sum <= (int_sum[48] != int_sum[47]) ?
                        (int_sum[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF) :
                        int_sum[47:0];
      end
      if (state == S_MD && mul_done) begin
        last_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ax     <= accel_x;
          ay     <= accel_y;
          az     <= accel_z;
          gx     <= gyro_x;
          gy     <= gyro_y;
          target <= target_roll;
          dt     <= stamp_ms - last_stamp;
          axis   <= 1'b0;
        end
      end
      S_SQB: if (mul_done) sumsq <= prod_mag[31:0];
      S_SQC: begin
        if (mul_done) begin
          rad   <= {sumsq + prod_mag[31:0], 28'd0};
          rem_r <= '0;
          root  <= '0;
        end
      end
      S_ROOT: begin
        rem_r <= rt_take ? 32'(rt_cur - rt_trial) : 32'(rt_cur);
        root  <= root_nv;
        rad   <= rad << 2;
        cx    <= CW'({1'b0, root_nv});
        cy    <= CW'(a_sel) <<< Y_SHIFT;
        cz    <= '0;
      end
      S_CORD: begin
        cx      <= cx_n;
        cy      <= cy_n;
        cz      <= cz_n;
        acc_ang <= acc_nv;
      end
      S_GYRO: if (mul_done) gyro_mag <= prod_mag[47:0];
      S_INC: begin
        if (div_done) begin
          prop <= (prop_sum[49:31] != {19{prop_sum[49]}}) ?
                  (prop_sum[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : prop_sum[31:0];
        end
      end
      S_BLG: if (mul_done) m1 <= prod[49:0];
      S_BLA: begin
        if (mul_done) begin
          axis <= 1'b1;
        end
      end
      S_MP: begin
        if (mul_done) p_term <= prod[55:16];
      end
      S_MI: ;
      S_MD: if (mul_done) dq <= prod[56:16];
      S_MT: begin
        if (mul_done) begin
          t_val  <= prod[50:0];
          d_term <= '0;
        end
      end
      S_DQ: if (div_done) d_term <= t_val[50] ? -qd : qd;
      S_OUT: begin
        if (out_load) begin
          drive     <= drive_nv;
          roll_est  <= roll_angle;
          pitch_est <= pitch_angle;
        end
      end
      default: ;
    endcase
    if (state == S_BLA && mul_done && axis) begin
      err <= err_nv;
    end
  end

  // The error is formed from the fused roll, which is final once pitch is done.
  `TFP_ASSERT_NXT(a_accept_starts, in_valid && !in_stall, state == S_SQB && !axis)
  `TFP_ASSERT_IMP(a_one_unit, 1'b1, !(mul_go && div_go))
  `TFP_ASSERT_IMP(a_cordic_range, state == S_CORD, step <= STEP_W'(CORDIC_STEPS - 1))
  `TFP_ASSERT_NXT(a_result_shown, out_load, out_valid && state == S_IDLE)
  `TFP_ASSERT_IMP(a_go_in_state, mul_go, state != S_IDLE && state != S_OUT)

endmodule

>>> bench/tilt_fusion_pid_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tilt fusion PID testbench
// Sends IMU sample requests through the valid/stall handshake and programs the
// gains, drive limit and gyro weight over the register port. A local model of
// the fusion and PID predicts every result. The monitor checks each result
// against the oldest prediction, with random idles and stalls in some phases.
// ---------------------------------------------------------------------------
module tilt_fusion_pid_test;
  import tfp_pkg::*;

  localparam int REG_GAIN_P = 0;
  localparam int REG_GAIN_I = 1;
  localparam int REG_GAIN_D = 2;
  localparam int REG_DRIVE_LIMIT = 3;
  localparam int REG_GYRO_WEIGHT = 4;
  localparam int CORDIC_N = CORDIC_STEPS_DEF;
  localparam int FRAC = ANGLE_FRAC_BITS;
  localparam int SETTLE_CYCLES = 500;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint I32_HI = 64'sd2147483647;
  localparam longint I32_LO = -64'sd2147483648;
  localparam longint I48_HI = 64'sd140737488355327;
  localparam longint I48_LO = -64'sd140737488355328;

  typedef struct {
    logic signed [15:0] ax, ay, az, gx, gy;
    logic [31:0] stamp;
    logic signed [31:0] target;
  } sample_t;

  typedef struct {
    logic [31:0] drive, roll, pitch;
  } estimate_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0, gyro_x = '0, gyro_y = '0;
  logic [31:0] stamp_ms = '0;
  logic signed [31:0] target_roll = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] drive, roll_est, pitch_est;

  tilt_fusion_pid dut (.*);

  always #5 clk = ~clk;

  sample_t pending_samples[$];
  estimate_t expected_estimates[$];
  sample_t sample_on_bus;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  logic [31:0] clock_ms = '0;

  longint gain_p_m, gain_i_m, gain_d_m, limit_m, weight_m;
  longint roll_m, pitch_m, integral_m, last_err_m;
  logic [31:0] last_stamp_m;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint arctan_q24(int i);
    longint unsigned big, lin, cub;
    case (i)
      0: return 754974720;
      1: return 445687602;
      2: return 235489088;
      3: return 119537938;
      4: return 60000934;
      5: return 30029717;
      default: begin
        big = 64'd961263669 << 20;
        lin = big >> i;
        cub = (3 * i < 64) ? (big >> (3 * i)) / 3 : 64'd0;
        return longint'((lin - cub + 64'd524288) >> 20);
      end
    endcase
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint accel_tilt(longint a, longint b, longint c);
    longint x, y, z, nx;
    if (a == 0) return 0;
    x = longint'(floor_sqrt(longint'(b * b + c * c) << 28));
    y = a * 16384;
    z = 0;
    for (int i = 0; i < CORDIC_N; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + arctan_q24(i);
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - arctan_q24(i);
      end
      x = nx;
    end
    return (z + (64'sd1 << (23 - FRAC))) >>> (24 - FRAC);
  endfunction

  function automatic longint blend(longint angle, longint raw, longint dt, longint acc);
    longint unsigned mag, q, r;
    longint inc, prop;
    mag = longint'(raw < 0 ? -raw : raw) * dt;
    q = mag / 131000;
    r = mag % 131000;
    inc = longint'((q << FRAC) + ((r << FRAC) + 65500) / 131000);
    prop = clamp(angle + (raw < 0 ? -inc : inc), I32_LO, I32_HI);
    return (weight_m * prop + (65536 - weight_m) * acc + 32768) >>> 16;
  endfunction

  function automatic estimate_t fuse_and_control(sample_t s);
    estimate_t e;
    longint dt, err, p, d, t, lim, out;
    dt = longint'(32'(s.stamp - last_stamp_m));
    last_stamp_m = s.stamp;
    roll_m = blend(roll_m, s.gx, dt, accel_tilt(s.ay, s.ax, s.az));
    pitch_m = blend(pitch_m, s.gy, dt, accel_tilt(-longint'(s.ax), s.ay, s.az));
    err = clamp(roll_m - longint'(s.target), I32_LO, I32_HI);
    p = (gain_p_m * err) >>> 16;
    integral_m = clamp(integral_m + ((gain_i_m * err) >>> 16), I48_LO, I48_HI);
    d = 0;
    if (dt != 0) begin
      t = ((gain_d_m * (err - last_err_m)) >>> 16) * 1000;
      d = (t < 0 ? -t : t) / dt;
      if (t < 0) d = -d;
    end
    last_err_m = err;
    lim = clamp(limit_m << FRAC, 0, I32_HI);
    out = clamp(p + integral_m + d, -lim, lim);
    e.drive = out[31:0];
    e.roll = roll_m[31:0];
    e.pitch = pitch_m[31:0];
    return e;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_estimates.push_back(fuse_and_control(sample_on_bus));
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_on_bus = pending_samples.pop_front();
          accel_x <= sample_on_bus.ax;
          accel_y <= sample_on_bus.ay;
          accel_z <= sample_on_bus.az;
          gyro_x <= sample_on_bus.gx;
          gyro_y <= sample_on_bus.gy;
          stamp_ms <= sample_on_bus.stamp;
          target_roll <= sample_on_bus.target;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    estimate_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_estimates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Result with no pending request.");
      end else begin
        e = expected_estimates.pop_front();
        if (drive !== e.drive || roll_est !== e.roll || pitch_est !== e.pitch) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: expected drive %h roll %h pitch %h, got %h %h %h",
                     e.drive, e.roll, e.pitch, drive, roll_est, pitch_est);
          end
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (pending_samples.size() == 0 && expected_estimates.size() == 0 && !in_valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[tilt_fusion_pid] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(input int idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GAIN_P: gain_p_m = longint'($signed(val[23:0]));
      REG_GAIN_I: gain_i_m = longint'($signed(val[23:0]));
      REG_GAIN_D: gain_d_m = longint'($signed(val[23:0]));
      REG_DRIVE_LIMIT: limit_m = longint'(val[14:0]);
      REG_GYRO_WEIGHT: weight_m = longint'(val[15:0]);
      default: ;
    endcase
  endtask

  task automatic program_all(input logic [31:0] gp, gi, gd, lim, wt);
    reg_write(REG_GAIN_P, gp);
    reg_write(REG_GAIN_I, gi);
    reg_write(REG_GAIN_D, gd);
    reg_write(REG_DRIVE_LIMIT, lim);
    reg_write(REG_GYRO_WEIGHT, wt);
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || expected_estimates.size() > 0 || in_valid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_sample(input logic [15:0] ax, ay, az, gx, gy,
                            input logic [31:0] stamp, target);
    sample_t s;
    s.ax = ax; s.ay = ay; s.az = az; s.gx = gx; s.gy = gy;
    s.stamp = stamp; s.target = target;
    clock_ms = stamp;
    pending_samples.push_back(s);
  endtask

  task automatic add_random(input int n);
    logic [31:0] step;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: step = $urandom;
        1: step = 0;
        default: step = $urandom_range(1, 40);
      endcase
      if ($urandom_range(3) == 0) begin
        add_sample($urandom, $urandom, $urandom, $urandom, $urandom,
                   clock_ms + step, $urandom);
      end else begin
        add_sample(16'($signed($urandom_range(0, 4000)) - 2000),
                   16'($signed($urandom_range(0, 4000)) - 2000),
                   16'($signed($urandom_range(15000, 17500))),
                   16'($signed($urandom_range(0, 2000)) - 1000),
                   16'($signed($urandom_range(0, 2000)) - 1000),
                   clock_ms + step, 32'($signed($urandom_range(0, 1310720)) - 655360));
      end
    end
  endtask

  initial begin
    gain_p_m = 65536; gain_i_m = 65536; gain_d_m = 65536;
    limit_m = 1000; weight_m = 64225;
    roll_m = 0; pitch_m = 0; integral_m = 0; last_err_m = 0; last_stamp_m = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    add_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0);
    add_sample(16'd0, 16'd0, 16'd16384, 16'd131, 16'hff7d, 32'd10, 32'd0);
    add_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 32'd20, 32'h7fffffff);
    add_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'd20, 32'h80000000);
    add_sample(16'h8000, 16'h7fff, 16'd0, 16'h8000, 16'h7fff, 32'hffffffff, 32'd0);
    add_sample(16'd0, 16'h7fff, 16'd0, 16'd0, 16'd0, 32'd5, 32'h80000000);
    add_sample(16'd100, 16'd0, 16'd0, 16'h7fff, 16'h8000, 32'hfffffff0, 32'h7fffffff);
    add_sample(16'hffff, 16'd1, 16'hffff, 16'd1, 16'hffff, 32'hfffffff0, 32'd65536);
    add_sample(16'd0, 16'd0, 16'h8000, 16'd65, 16'hffbf, 32'h00000003, 32'hffff0000);
    add_random(140);
    send_idle_pct = 0; stall_pct = 0;
    wait_drained();

    program_all(32'h7fffff, 32'h7fffff, 32'h7fffff, 32'd32767, 32'd65535);
    add_random(160);
    send_idle_pct = 75; stall_pct = 0;
    wait_drained();

    program_all(32'h800000, 32'h800000, 32'h800000, 32'd0, 32'd0);
    add_random(160);
    send_idle_pct = 0; stall_pct = 75;
    wait_drained();

    program_all($urandom, $urandom_range(0, 4096), $urandom,
                $urandom_range(1, 32767), $urandom);
    send_idle_pct = 12; stall_pct = 12;
    add_random(80);
    wait_drained();
    program_all(32'd65536, 32'd0, 32'hff0000, 32'd500, 32'd64225);
    add_random(80);
    wait_drained();

    if (mismatch_count == 0 && expected_estimates.size() == 0) begin
      $display("[tilt_fusion_pid] OK");
    end else begin
      $display("[tilt_fusion_pid] ERROR");
    end
    $finish;
  end

endmodule
